FILE: design/qsc_pkg.sv
// Package for the quantile sketch compactor.
// Holds the sequencer state type, request kinds and configuration register indexes.
// No dependencies.
package qsc_pkg;

  localparam int unsigned RANK_W = 40;
  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 40;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned TOP_W  = 4;

  localparam logic [CFG_IW-1:0] REG_LEVEL_CAPACITY = 2'd0;
  localparam logic [CFG_IW-1:0] REG_TOP_LEVEL      = 2'd1;
  localparam logic [CFG_IW-1:0] REG_STREAM_LENGTH  = 2'd2;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_RANK   = 2'd1,
    KIND_SELECT = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS,
    ST_CHECK,
    ST_FETCH,
    ST_LOAD,
    ST_CNT,
    ST_PLACE,
    ST_PREAD,
    ST_PWRITE,
    ST_CLEAR,
    ST_SCAN,
    ST_EVAL,
    ST_OUT
  } sketch_state_e;

endpackage

FILE: design/quantile_sketch_compactor.sv
// Top level of the quantile sketch compactor: level store, sequencer and shared compare unit.
// Depends on qsc_pkg.
//
// Streaming quantile sketch (compactor stack). Each request is taken only while
// in_stall_o is low and runs to completion before the next one; a finished result
// sits in the output register, so a new request can start while it waits.
// Values live biased (sign bit flipped) in one single-port-read level store of
// MAX_LEVELS x MAX_CAPACITY entries, so one stored entry is compared per cycle.
// Request steps, with n the fill of a level and k the level capacity:
//   insert, no compaction       : one store write, then a fill check
//   each compacted level        : a ranking pass over the level per entry, then every
//                                 other of the lowest k sorted entries moves up a level
//   rank query                  : one scan
//   select query                : up to (VALUE_WIDTH + 1) scans;
//                                 the value is found one bit a scan, MSB first.
// No clearing pass: level fills reset to zero and only entries below a fill are read.
// Unknown request kind is dropped, no result.
module quantile_sketch_compactor
  import qsc_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = 64,
  parameter int unsigned MAX_LEVELS   = 16,
  parameter int unsigned VALUE_WIDTH  = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  input  logic signed [VALUE_WIDTH-1:0]  item_value_i,
  input  logic [RANK_W-1:0]              target_rank_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [RANK_W-1:0]              rank_result_o,
  output logic signed [VALUE_WIDTH-1:0]  selected_value_o,
  output logic                           status_o,
  input  logic                           cfg_we_i,
  input  logic [CFG_IW-1:0]              cfg_index_i,
  input  logic [CFG_DW-1:0]              cfg_data_i
);

  localparam int unsigned DEPTH = MAX_LEVELS * MAX_CAPACITY;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned BW    = AW + 2;
  localparam int unsigned FW    = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned TW    = FW + 1;
  localparam int unsigned CW    = $clog2(MAX_CAPACITY);
  localparam int unsigned LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned LCW   = $clog2(MAX_LEVELS + 1);
  localparam int unsigned TOP_MAX = MAX_LEVELS - 1;
  localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] ALL_ONES = {VALUE_WIDTH{1'b1}};

  // state
  sketch_state_e state_q, state_d;

  // configuration
  logic [CAP_W-1:0]  cap_cfg_q;
  logic [TOP_W-1:0]  top_cfg_q;
  logic [RANK_W-1:0] len_cfg_q;

  // request
  kind_e                   kind_q, kind_d;
  logic [VALUE_WIDTH-1:0]  key_q, key_d;
  logic [RANK_W-1:0]       r_q, r_d;

  // level fills
  logic [FW-1:0]  fill_q [MAX_LEVELS];
  logic           fill_we;
  logic [LCW-1:0] fill_widx;
  logic [FW-1:0]  fill_wdata;
  logic [LCW-1:0] fill_ridx;
  logic [FW-1:0]  fill_rd;

  // level store and sort scratch
  logic [VALUE_WIDTH-1:0] store_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] st_rdata_q;
  logic                   st_we;
  logic [AW-1:0]          st_waddr, st_raddr;
  logic [VALUE_WIDTH-1:0] st_wdata;
  logic [VALUE_WIDTH-1:0] scr_mem [MAX_CAPACITY];
  logic [VALUE_WIDTH-1:0] sc_rdata_q;
  logic                   sc_we;
  logic [CW-1:0]          sc_waddr, sc_raddr;

  // walk counters
  logic [LCW-1:0] lvl_q, lvl_d;
  logic [FW-1:0]  idx_q, idx_d;
  logic [BW-1:0]  base_q, base_d;
  logic [FW-1:0]  n_q, n_d;
  logic [FW-1:0]  i_q, i_d;
  logic [FW-1:0]  m_q, m_d;
  logic [FW-1:0]  cnt_q, cnt_d;
  logic [TW-1:0]  t_q, t_d;
  logic [VALUE_WIDTH-1:0] piv_q, piv_d;

  // read pipeline tag
  logic           pv_q, pv_d;
  logic [FW-1:0]  pm_q, pm_d;
  logic [LCW-1:0] pw_q, pw_d;

  // query scan
  logic [RANK_W-1:0]      acc_q, acc_d;
  logic                   any_q, any_d;
  logic [VALUE_WIDTH-1:0] max_q, max_d;
  logic [VALUE_WIDTH-1:0] vsel_q, vsel_d;
  logic [VALUE_WIDTH-1:0] mask_q, mask_d;
  logic                   phase_q, phase_d;

  // output register
  logic                   out_valid_q;
  logic [RANK_W-1:0]      out_rank_q;
  logic [VALUE_WIDTH-1:0] out_val_q;
  logic                   out_status_q;
  logic                   out_load;

  // effective configuration
  logic [FW-1:0]  k_eff;
  logic [LCW-1:0] top_eff;
  logic [31:0]    k_tmp, top_tmp;

  always_comb begin
    k_tmp = {{(32-CAP_W){1'b0}}, cap_cfg_q};
    if (k_tmp > MAX_CAPACITY) k_tmp = MAX_CAPACITY;
    k_tmp[0] = 1'b0;
    if (k_tmp < 32'd2) k_tmp = 32'd2;
    k_eff = k_tmp[FW-1:0];
    top_tmp = {{(32-TOP_W){1'b0}}, top_cfg_q};
    if (top_tmp > TOP_MAX) top_tmp = TOP_MAX;
    top_eff = top_tmp[LCW-1:0];
  end

  // request rank clamped to 1..n
  logic [RANK_W-1:0] r_clamp, n_eff;
  always_comb begin
    n_eff   = (len_cfg_q == '0) ? RANK_W'(1) : len_cfg_q;
    r_clamp = (target_rank_i == '0) ? RANK_W'(1) : target_rank_i;
    if (r_clamp > n_eff) r_clamp = n_eff;
  end

  // shared status terms
  logic in_accept, lvl_in, scan_has, scan_end, cnt_end, prom_ok, prom_more, place_more;
  logic need_compact;

  assign in_accept = in_valid_i && !in_stall_o;
  assign fill_ridx = (state_q == ST_PWRITE) ? (lvl_q + LCW'(1)) : lvl_q;
  assign fill_rd   = (fill_ridx < LCW'(MAX_LEVELS)) ? fill_q[fill_ridx[LW-1:0]] : '0;
  assign lvl_in    = (lvl_q <= top_eff);
  assign scan_has  = (idx_q < fill_rd);
  assign scan_end  = !lvl_in && !pv_q;
  assign cnt_end   = (m_q == n_q) && !pv_q;
  assign prom_ok   = (lvl_q < top_eff);
  assign prom_more = ((t_q + TW'(1)) < {1'b0, k_eff}) && (t_q < {1'b0, n_q});
  assign place_more = (({1'b0, i_q} + TW'(1)) < {1'b0, n_q});
  assign need_compact = lvl_in && (fill_rd >= k_eff);

  // compare unit: stored key against threshold
  logic [VALUE_WIDTH-1:0] thr;
  logic                   hit;
  always_comb begin
    if (kind_q == KIND_RANK)   thr = key_q;
    else if (!phase_q)         thr = ALL_ONES;
    else                       thr = vsel_q | mask_q;
    hit = (kind_q == KIND_RANK) ? (st_rdata_q < thr) : (st_rdata_q <= thr);
  end

  // saturating add of weight 2^level
  logic [RANK_W-1:0] acc_add;
  logic [RANK_W:0]   acc_sum;
  always_comb begin
    acc_sum = {1'b0, acc_q} + ((RANK_W+1)'(1) << pw_q);
    if (32'(pw_q) >= RANK_W || acc_sum > {1'b0, RANK_MAX}) acc_add = RANK_MAX;
    else acc_add = acc_sum[RANK_W-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (kind_e'(kind_i))
            KIND_INSERT:             state_d = ST_INS;
            KIND_RANK, KIND_SELECT:  state_d = ST_SCAN;
            default:                 state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS:    state_d = ST_CHECK;
      ST_CHECK:  state_d = need_compact ? ST_FETCH : ST_IDLE;
      ST_FETCH:  state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_CNT;
      ST_CNT:    state_d = cnt_end ? ST_PLACE : ST_CNT;
      ST_PLACE:  state_d = place_more ? ST_FETCH : ST_PREAD;
      ST_PREAD:  state_d = (prom_ok && prom_more) ? ST_PWRITE : ST_CLEAR;
      ST_PWRITE: state_d = ST_PREAD;
      ST_CLEAR:  state_d = ST_CHECK;
      ST_SCAN:   state_d = scan_end ? ST_EVAL : ST_SCAN;
      ST_EVAL: begin
        priority if (kind_q == KIND_RANK)  state_d = ST_OUT;
        else if (!phase_q) state_d = (!any_q || acc_q < r_q) ? ST_OUT : ST_SCAN;
        else               state_d = (mask_q == '0) ? ST_OUT : ST_SCAN;
      end
      ST_OUT:    state_d = (!out_valid_q || !out_stall_i) ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    kind_d = kind_q;   key_d = key_q;   r_d = r_q;
    lvl_d = lvl_q;     idx_d = idx_q;   base_d = base_q;
    n_d = n_q;         i_d = i_q;       m_d = m_q;
    cnt_d = cnt_q;     t_d = t_q;       piv_d = piv_q;
    pv_d = 1'b0;       pm_d = pm_q;     pw_d = pw_q;
    acc_d = acc_q;     any_d = any_q;   max_d = max_q;
    vsel_d = vsel_q;   mask_d = mask_q; phase_d = phase_q;
    fill_we = 1'b0;    fill_widx = lvl_q; fill_wdata = '0;
    st_we = 1'b0;      st_waddr = '0;   st_wdata = key_q;
    st_raddr = '0;
    sc_we = 1'b0;      sc_waddr = cnt_q[CW-1:0]; sc_raddr = t_q[CW-1:0];
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          kind_d  = kind_e'(kind_i);
          key_d   = $unsigned(item_value_i) ^ SIGN_BIT;
          r_d     = r_clamp;
          lvl_d   = '0;
          idx_d   = '0;
          base_d  = '0;
          acc_d   = '0;
          any_d   = 1'b0;
          max_d   = '0;
          phase_d = 1'b0;
        end
      end
      ST_INS: begin
        if (fill_rd < FW'(MAX_CAPACITY)) begin
          st_we      = 1'b1;
          st_waddr   = AW'(fill_rd);
          fill_we    = 1'b1;
          fill_wdata = fill_rd + FW'(1);
        end
      end
      ST_CHECK: begin
        n_d = fill_rd;
        i_d = '0;
      end
      ST_FETCH: st_raddr = AW'(base_q + BW'(i_q));
      ST_LOAD: begin
        piv_d = st_rdata_q;
        m_d   = '0;
        cnt_d = '0;
      end
      ST_CNT: begin
        // rank of the pivot among the level, ties broken by position
        if (pv_q && ((st_rdata_q < piv_q) || (st_rdata_q == piv_q && pm_q < i_q)))
          cnt_d = cnt_q + FW'(1);
        if (m_q != n_q) begin
          st_raddr = AW'(base_q + BW'(m_q));
          pv_d     = 1'b1;
          pm_d     = m_q;
          m_d      = m_q + FW'(1);
        end
      end
      ST_PLACE: begin
        sc_we = 1'b1;
        i_d   = i_q + FW'(1);
        t_d   = '0;
      end
      ST_PREAD: ;
      ST_PWRITE: begin
        if (fill_rd < FW'(MAX_CAPACITY)) begin
          st_we      = 1'b1;
          st_waddr   = AW'(base_q + BW'(MAX_CAPACITY) + BW'(fill_rd));
          st_wdata   = sc_rdata_q;
          fill_we    = 1'b1;
          fill_widx  = lvl_q + LCW'(1);
          fill_wdata = fill_rd + FW'(1);
        end
        t_d = t_q + TW'(2);
      end
      ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_wdata = '0;
        lvl_d      = lvl_q + LCW'(1);
        base_d     = base_q + BW'(MAX_CAPACITY);
      end
      ST_SCAN: begin
        if (pv_q) begin
          if (hit) acc_d = acc_add;
          if (!any_q || st_rdata_q > max_q) max_d = st_rdata_q;
          any_d = 1'b1;
        end
        if (lvl_in) begin
          if (scan_has) begin
            st_raddr = AW'(base_q + BW'(idx_q));
            pv_d     = 1'b1;
            pw_d     = lvl_q;
            idx_d    = idx_q + FW'(1);
          end else begin
            lvl_d  = lvl_q + LCW'(1);
            idx_d  = '0;
            base_d = base_q + BW'(MAX_CAPACITY);
          end
        end
      end
      ST_EVAL: begin
        lvl_d  = '0;
        idx_d  = '0;
        base_d = '0;
        if (kind_q != KIND_RANK) begin
          // rank count is kept for the output register; select restarts it per scan
          acc_d = '0;
          if (!phase_q) begin
            // nothing reaches the rank: largest stored value
            if (acc_q < r_q) vsel_d = max_q;
            else begin
              vsel_d  = '0;
              mask_d  = ALL_ONES >> 1;
              phase_d = 1'b1;
            end
          end else begin
            if (acc_q < r_q) vsel_d = vsel_q | (mask_q + VALUE_WIDTH'(1));
            mask_d = mask_q >> 1;
          end
        end
      end
      ST_OUT: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    st_rdata_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) scr_mem[sc_waddr] <= piv_q;
    sc_rdata_q <= scr_mem[sc_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_cfg_q   <= CAP_W'(64);
      top_cfg_q   <= TOP_W'(15);
      len_cfg_q   <= RANK_W'(65536);
      pv_q        <= 1'b0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      for (int unsigned l = 0; l < MAX_LEVELS; l++) fill_q[l] <= '0;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
      lvl_q   <= lvl_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_LEVEL_CAPACITY: cap_cfg_q <= cfg_data_i[CAP_W-1:0];
          REG_TOP_LEVEL:      top_cfg_q <= cfg_data_i[TOP_W-1:0];
          REG_STREAM_LENGTH:  len_cfg_q <= cfg_data_i[RANK_W-1:0];
          default: ;
        endcase
      end
      if (fill_we) fill_q[fill_widx[LW-1:0]] <= fill_wdata;
      if (out_load)                     out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;   key_q  <= key_d;   r_q    <= r_d;
    idx_q   <= idx_d;    base_q <= base_d;
    n_q     <= n_d;      i_q    <= i_d;     m_q    <= m_d;
    cnt_q   <= cnt_d;    t_q    <= t_d;     piv_q  <= piv_d;
    pm_q    <= pm_d;     pw_q   <= pw_d;
    acc_q   <= acc_d;    any_q  <= any_d;   max_q  <= max_d;
    vsel_q  <= vsel_d;   mask_q <= mask_d;  phase_q <= phase_d;
    if (out_load) begin
      out_rank_q   <= (kind_q == KIND_RANK) ? acc_q : '0;
      out_val_q    <= (kind_q == KIND_SELECT && any_q) ? (vsel_q ^ SIGN_BIT) : '0;
      out_status_q <= (kind_q == KIND_SELECT) && !any_q;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign rank_result_o    = out_rank_q;
  assign selected_value_o = $signed(out_val_q);
  assign status_o         = out_status_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_rd <= FW'(MAX_CAPACITY))
    else $error("level fill above capacity");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && kind_i != KIND_NONE) |=> (state_q != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (state_q == ST_SCAN || state_q == ST_CNT))
    else $error("read tag live outside a scan");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (selected_value_o == '0 && rank_result_o == '0))
    else $error("error result carries data");
`endif

endmodule
